>>> src/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

>>> src/srexu_pkg.sv
// Types and constants of the execute unit.
package srexu_pkg;

	localparam int unsigned MEM_WORDS  = 128;
	localparam int unsigned MEM_AW     = $clog2(MEM_WORDS);
	localparam int unsigned PROG_LINES = 1024;
	localparam int unsigned LINE_W     = 11;
	localparam int unsigned PC_BASE    = 3996;  // 4000 - 4
	localparam int unsigned LINK_REG   = 14;
	localparam int unsigned PC_REG     = 15;

	localparam logic CFG_LAT_ALU  = 1'b0;
	localparam logic CFG_LAT_FLOW = 1'b1;

	// latency byte slots
	localparam int unsigned SLOT_ADD = 0;
	localparam int unsigned SLOT_SUB = 1;
	localparam int unsigned SLOT_MUL = 2;
	localparam int unsigned SLOT_MOV = 3;
	localparam int unsigned SLOT_CMP = 4;
	localparam int unsigned SLOT_BNE = 0;
	localparam int unsigned SLOT_B   = 1;
	localparam int unsigned SLOT_BGE = 2;
	localparam int unsigned SLOT_BL  = 3;
	localparam int unsigned SLOT_STR = 4;
	localparam int unsigned SLOT_LDR = 5;

	typedef enum logic [3:0] {
		OP_ADDR     = 4'd0,
		OP_ADDI     = 4'd1,
		OP_SUBR     = 4'd2,
		OP_SUBI     = 4'd3,
		OP_MUL      = 4'd4,
		OP_MOVR     = 4'd5,
		OP_MOVI     = 4'd6,
		OP_CMPBNE_R = 4'd7,
		OP_CMPBNE_I = 4'd8,
		OP_CMPBGE_R = 4'd9,
		OP_CMPBGE_I = 4'd10,
		OP_LDR      = 4'd11,
		OP_STR      = 4'd12,
		OP_B        = 4'd13,
		OP_BL       = 4'd14,
		OP_SKIP     = 4'd15
	} op_t;

	typedef logic [LINE_W-1:0] line_t;

	function automatic line_t clamp_line(input logic [LINE_W:0] v);
		line_t r;
		if (v > (LINE_W+1)'(PROG_LINES)) begin
			r = LINE_W'(PROG_LINES);
		end else begin
			r = v[LINE_W-1:0];
		end
		return r;
	endfunction

endpackage

>>> src/simple_risc_execute_unit_core.sv
// Execute unit: register file, data memory, line tracking and cycle accounting.

// One decoded instruction per cycle is accepted and one result per cycle is delivered, unless
// a stall holds them. Each instruction passes three registers: the input register, where the
// two register-file reads and the data-memory read are issued (forwarded from the instruction
// ahead), the execute register, where the ALU, branch decision and write-back take place,
// and the result register, from which the result is delivered; a stall on the result side
// backs up through these stages and the input stall rises only once they are full. The data
// memory keeps a valid bit per word, so reset needs no clearing pass.

`include "assert_macros.svh"

module simple_risc_execute_unit_core (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  operation,
	input  logic [3:0]  dest_reg,
	input  logic [3:0]  first_reg,
	input  logic [3:0]  second_reg,
	input  logic [26:0] immediate,
	input  logic [9:0]  target_line,

	output logic        out_valid,
	input  logic        out_stall,
	output logic        reg_write_valid,
	output logic [3:0]  reg_write_index,
	output logic signed [31:0] reg_write_value,
	output logic [10:0] next_line,
	output logic [12:0] pc_value,
	output logic [31:0] total_cycles,
	output logic [31:0] instruction_count,
	output logic        status,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [47:0] cfg_data
);

	// configuration
	logic [39:0] lat_alu_q;
	logic [47:0] lat_flow_q;

	// architectural state
	logic [31:0]             rf_q [0:srexu_pkg::PC_REG-1];
	logic [31:0]             pc_q;
	logic [31:0]             mem_q [0:srexu_pkg::MEM_WORDS-1];
	logic [srexu_pkg::MEM_WORDS-1:0] mem_vld_q;
	srexu_pkg::line_t        line_q;
	logic [31:0]             cyc_q;
	logic [31:0]             cnt_q;

	// input stage
	logic              s1_valid;
	srexu_pkg::op_t    op_s1;
	logic [3:0]        rd_s1, rn_s1, rm_s1;
	logic [26:0]       imm_s1;
	logic [9:0]        tgt_s1;

	// execute stage
	logic              s2_valid;
	srexu_pkg::op_t    op_s2;
	logic [3:0]        rd_s2;
	logic [26:0]       imm_s2;
	logic [9:0]        tgt_s2;
	logic [31:0]       opx_s2, opy_s2;
	logic              addr_ok_s2;
	logic [srexu_pkg::MEM_AW-1:0] addr_s2;
	logic [31:0]       mem_rd_s2;
	logic              mem_vld_s2;
	logic              st_hit_s2;
	logic [31:0]       st_data_s2;

	// result register
	logic              out_valid_q;

	logic s1_go, s2_go;

	// input stage reads
	logic [3:0]    px, py;
	logic [31:0]   px_val, py_val;
	logic [33:0]   addr_sum;
	logic          addr_ok;
	logic [srexu_pkg::MEM_AW-1:0] addr_idx;
	logic          st_hit;

	// execute results
	logic              wr;
	logic [3:0]        widx;
	logic [31:0]       wval;
	logic              stat;
	logic              taken;
	logic              is_fused;
	logic              mem_we;
	logic [7:0]        lat_a, lat_b;
	logic [1:0]        cnt_inc;
	srexu_pkg::line_t  nxt;
	srexu_pkg::line_t  line_inc1, line_inc2, tgt_line;
	logic [12:0]       pc_new;
	logic [33:0]       cyc_sum, cnt_sum;
	logic [31:0]       cyc_new, cnt_new;
	logic [31:0]       imm32;
	logic [31:0]       ld_data;

	// handshake
	assign s2_go    = s2_valid && (!out_valid_q || !out_stall);
	assign s1_go    = s1_valid && (!s2_valid || s2_go);
	assign in_stall = s1_valid && !s1_go;
	assign out_valid = out_valid_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lat_alu_q  <= '0;
			lat_flow_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				srexu_pkg::CFG_LAT_ALU:  lat_alu_q  <= cfg_data[39:0];
				srexu_pkg::CFG_LAT_FLOW: lat_flow_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- input stage ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (in_valid && !in_stall) begin
			s1_valid <= 1'b1;
		end else if (s1_go) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1  <= srexu_pkg::op_t'(operation);
			rd_s1  <= dest_reg;
			rn_s1  <= first_reg;
			rm_s1  <= second_reg;
			imm_s1 <= immediate;
			tgt_s1 <= target_line;
		end
	end

	// Read ports: compares read rd on port x, stores read the data register on port y.
	always_comb begin
		px = rn_s1;
		py = rm_s1;
		case (op_s1) inside
			srexu_pkg::OP_CMPBNE_R, srexu_pkg::OP_CMPBNE_I,
			srexu_pkg::OP_CMPBGE_R, srexu_pkg::OP_CMPBGE_I: px = rd_s1;
			srexu_pkg::OP_STR: py = rd_s1;
			default: ;
		endcase
	end

	// Forward from the instruction in execute; it commits whenever s1 moves on.
	always_comb begin
		if (px == 4'(srexu_pkg::PC_REG)) begin
			px_val = s2_valid ? 32'(pc_new) : pc_q;
		end else if (s2_valid && wr && widx == px) begin
			px_val = wval;
		end else begin
			px_val = rf_q[px];
		end
		if (py == 4'(srexu_pkg::PC_REG)) begin
			py_val = s2_valid ? 32'(pc_new) : pc_q;
		end else if (s2_valid && wr && widx == py) begin
			py_val = wval;
		end else begin
			py_val = rf_q[py];
		end
	end

	assign addr_sum = {{2{px_val[31]}}, px_val} + 34'(imm_s1);
	assign addr_ok  = !addr_sum[33] && (addr_sum[32:0] < 33'(srexu_pkg::MEM_WORDS));
	assign addr_idx = addr_sum[srexu_pkg::MEM_AW-1:0];
	assign st_hit   = mem_we && (addr_s2 == addr_idx);

	// ---------------- execute stage ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid <= 1'b0;
		end else if (s1_go) begin
			s2_valid <= 1'b1;
		end else if (s2_go) begin
			s2_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			op_s2      <= op_s1;
			rd_s2      <= rd_s1;
			imm_s2     <= imm_s1;
			tgt_s2     <= tgt_s1;
			opx_s2     <= px_val;
			opy_s2     <= py_val;
			addr_ok_s2 <= addr_ok;
			addr_s2    <= addr_idx;
			mem_vld_s2 <= mem_vld_q[addr_idx];
			st_hit_s2  <= st_hit;
			st_data_s2 <= opy_s2;
		end
	end

	// data memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[addr_s2] <= opy_s2;
		end
		if (s1_go) begin
			mem_rd_s2 <= mem_q[addr_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_vld_q <= '0;
		end else if (mem_we) begin
			mem_vld_q[addr_s2] <= 1'b1;
		end
	end

	// store in the same transfer as the read wins; unwritten words read as zero
	assign ld_data = st_hit_s2 ? st_data_s2 : (mem_vld_s2 ? mem_rd_s2 : 32'd0);
	assign imm32   = 32'(imm_s2);

	assign line_inc1 = srexu_pkg::clamp_line(12'(line_q) + 12'd1);
	assign line_inc2 = srexu_pkg::clamp_line(12'(line_q) + 12'd2);
	assign tgt_line  = srexu_pkg::clamp_line(12'(tgt_s2));

	always_comb begin
		wr       = 1'b0;
		widx     = '0;
		wval     = '0;
		stat     = 1'b0;
		taken    = 1'b0;
		is_fused = 1'b0;
		mem_we   = 1'b0;
		lat_a    = '0;
		lat_b    = '0;
		cnt_inc  = 2'd1;
		nxt      = line_inc1;
		unique case (op_s2) inside
			srexu_pkg::OP_ADDR, srexu_pkg::OP_ADDI: begin
				lat_a = lat_alu_q[8*srexu_pkg::SLOT_ADD +: 8];
				wr    = 1'b1;
				widx  = rd_s2;
				wval  = opx_s2 + ((op_s2 == srexu_pkg::OP_ADDR) ? opy_s2 : imm32);
			end
			srexu_pkg::OP_SUBR, srexu_pkg::OP_SUBI: begin
				lat_a = lat_alu_q[8*srexu_pkg::SLOT_SUB +: 8];
				wr    = 1'b1;
				widx  = rd_s2;
				wval  = opx_s2 - ((op_s2 == srexu_pkg::OP_SUBR) ? opy_s2 : imm32);
			end
			srexu_pkg::OP_MUL: begin
				lat_a = lat_alu_q[8*srexu_pkg::SLOT_MUL +: 8];
				wr    = 1'b1;
				widx  = rd_s2;
				wval  = opx_s2 * opy_s2;
			end
			srexu_pkg::OP_MOVR, srexu_pkg::OP_MOVI: begin
				lat_a = lat_alu_q[8*srexu_pkg::SLOT_MOV +: 8];
				wr    = 1'b1;
				widx  = rd_s2;
				wval  = (op_s2 == srexu_pkg::OP_MOVR) ? opx_s2 : imm32;
			end
			srexu_pkg::OP_CMPBNE_R, srexu_pkg::OP_CMPBNE_I: begin
				is_fused = 1'b1;
				lat_a    = lat_alu_q[8*srexu_pkg::SLOT_CMP +: 8];
				lat_b    = lat_flow_q[8*srexu_pkg::SLOT_BNE +: 8];
				taken    = opx_s2 != ((op_s2 == srexu_pkg::OP_CMPBNE_R) ? opy_s2 : imm32);
			end
			srexu_pkg::OP_CMPBGE_R: begin
				is_fused = 1'b1;
				lat_a    = lat_alu_q[8*srexu_pkg::SLOT_CMP +: 8];
				lat_b    = lat_flow_q[8*srexu_pkg::SLOT_BGE +: 8];
				taken    = $signed(opx_s2) >= $signed(opy_s2);
			end
			srexu_pkg::OP_CMPBGE_I: begin
				// immediate is never negative
				is_fused = 1'b1;
				lat_a    = lat_alu_q[8*srexu_pkg::SLOT_CMP +: 8];
				lat_b    = lat_flow_q[8*srexu_pkg::SLOT_BGE +: 8];
				taken    = !opx_s2[31] && (opx_s2 >= imm32);
			end
			srexu_pkg::OP_LDR: begin
				lat_a = lat_flow_q[8*srexu_pkg::SLOT_LDR +: 8];
				stat  = !addr_ok_s2;
				wr    = addr_ok_s2;
				widx  = addr_ok_s2 ? rd_s2 : 4'd0;
				wval  = addr_ok_s2 ? ld_data : 32'd0;
			end
			srexu_pkg::OP_STR: begin
				lat_a  = lat_flow_q[8*srexu_pkg::SLOT_STR +: 8];
				stat   = !addr_ok_s2;
				mem_we = s2_go && addr_ok_s2;
			end
			srexu_pkg::OP_B: begin
				lat_a = lat_flow_q[8*srexu_pkg::SLOT_B +: 8];
				nxt   = tgt_line;
			end
			srexu_pkg::OP_BL: begin
				lat_a = lat_flow_q[8*srexu_pkg::SLOT_BL +: 8];
				wr    = 1'b1;
				widx  = 4'(srexu_pkg::LINK_REG);
				wval  = 32'(line_q) + 32'd1;
				nxt   = tgt_line;
			end
			srexu_pkg::OP_SKIP: begin
				cnt_inc = 2'd0;
			end
			default: ;
		endcase
		if (is_fused) begin
			cnt_inc = 2'd2;
			nxt     = taken ? tgt_line : line_inc2;
		end
	end

	assign pc_new = 13'(srexu_pkg::PC_BASE) + {nxt, 2'b00};

	// saturating accumulation; two saturating adds of a fused pair fold into one clamp
	assign cyc_sum = 34'(cyc_q) + 34'(lat_a) + 34'(lat_b);
	assign cnt_sum = 34'(cnt_q) + 34'(cnt_inc);
	assign cyc_new = (cyc_sum[33:32] != 2'b00) ? '1 : cyc_sum[31:0];
	assign cnt_new = (cnt_sum[33:32] != 2'b00) ? '1 : cnt_sum[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < int'(srexu_pkg::PC_REG); i++) begin
				rf_q[i] <= '0;
			end
			pc_q   <= '0;
			line_q <= '0;
			cyc_q  <= '0;
			cnt_q  <= '0;
		end else if (s2_go) begin
			// a write to r15 is reported but not stored; reads of r15 always return the pc
			if (wr && widx != 4'(srexu_pkg::PC_REG)) begin
				rf_q[widx] <= wval;
			end
			pc_q   <= 32'(pc_new);
			line_q <= nxt;
			cyc_q  <= cyc_new;
			cnt_q  <= cnt_new;
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go) begin
			reg_write_valid   <= wr;
			reg_write_index   <= wr ? widx : 4'd0;
			reg_write_value   <= wr ? wval : 32'd0;
			next_line         <= nxt;
			pc_value          <= pc_new;
			total_cycles      <= cyc_new;
			instruction_count <= cnt_new;
			status            <= stat;
		end
	end

	// ---------------- checks ----------------
	`ASSERT_IMPLY(a_pc_matches_line, clk, arst_n, out_valid_q, pc_value == 13'(13'(srexu_pkg::PC_BASE) + {next_line, 2'b00}))
	`ASSERT_IMPLY(a_no_write_zero, clk, arst_n, out_valid_q && !reg_write_valid, reg_write_index == 4'd0 && reg_write_value == 32'd0)
	`ASSERT_IMPLY(a_fault_no_write, clk, arst_n, out_valid_q && status, !reg_write_valid)
	`ASSERT_NEXT(a_count_monotonic, clk, arst_n, s2_go, cnt_q >= $past(cnt_q) && cyc_q >= $past(cyc_q))

endmodule
